/* hw/rtl/egc_pkg.sv */
// ============================================================================
// egc_pkg - shared types and constants for the entry gate counter
// Word layouts for both channels, the configuration bundle, register
// indexes and register reset values.
// ============================================================================
package egc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_TICKS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ANGLE    = 3'd6;

    // register reset values
    localparam logic [11:0] RST_ENTER_THRESHOLD = 12'd500;
    localparam logic [11:0] RST_LEAVE_THRESHOLD = 12'd1100;
    localparam logic [15:0] RST_SETTLE_TICKS    = 16'd300;
    localparam logic [15:0] RST_HOLD_TICKS      = 16'd3000;
    localparam logic [15:0] RST_WARN_TICKS      = 16'd3000;
    localparam logic [7:0]  RST_OPEN_ANGLE      = 8'd90;
    localparam logic [7:0]  RST_CLOSED_ANGLE    = 8'd0;

    typedef struct packed {
        logic [11:0] light_level;
        logic        metal_present;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  mode_code;
        logic [7:0]  gate_angle;
        logic        buzzer_on;
        logic [15:0] person_count;
        logic        counted_now;
    } t_out_word;

    typedef struct packed {
        logic [11:0] enter_threshold;
        logic [11:0] leave_threshold;
        logic [15:0] settle_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] warn_ticks;
        logic [7:0]  open_angle;
        logic [7:0]  closed_angle;
    } t_cfg;

endpackage

/* hw/rtl/egc_core.sv */
// ============================================================================
// egc_core - gate state machine
// Holds mode, tick timer, person count, buzzer and gate latch. One step per
// accepted word; the result reflects the state after that step.
// ============================================================================
module egc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  egc_pkg::t_cfg     i_cfg,
    input  logic              i_step,
    input  egc_pkg::t_in_word i_word,
    output egc_pkg::t_out_word o_result
);

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_WARN   = 5'b00010,
        MODE_SETTLE = 5'b00100,
        MODE_LEAVE  = 5'b01000,
        MODE_HOLD   = 5'b10000
    } t_mode;

    localparam logic [2:0] CODE_IDLE   = 3'd0;
    localparam logic [2:0] CODE_WARN   = 3'd1;
    localparam logic [2:0] CODE_SETTLE = 3'd2;
    localparam logic [2:0] CODE_LEAVE  = 3'd3;
    localparam logic [2:0] CODE_HOLD   = 3'd4;

    t_mode       r_mode, n_mode;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_count, n_count;
    logic        r_buzzer, n_buzzer;
    logic        r_gate_open, n_gate_open;
    logic        n_counted;
    logic [15:0] elapsed_inc;
    logic [2:0]  mode_code;

    // saturating tick count used by all timed modes
    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    always_comb begin
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_count     = r_count;
        n_buzzer    = r_buzzer;
        n_gate_open = r_gate_open;
        n_counted   = 1'b0;
        unique case (r_mode)
            MODE_WARN: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= i_cfg.warn_ticks) begin
                    n_mode    = MODE_IDLE;
                    n_elapsed = '0;
                    n_buzzer  = 1'b0;
                end
            end
            MODE_SETTLE: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= i_cfg.settle_ticks) begin
                    n_mode    = MODE_LEAVE;
                    n_elapsed = '0;
                end
            end
            MODE_LEAVE: begin
                if (i_word.light_level > i_cfg.leave_threshold) begin
                    n_mode    = MODE_HOLD;
                    n_elapsed = '0;
                end
            end
            MODE_HOLD: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= i_cfg.hold_ticks) begin
                    n_mode      = MODE_IDLE;
                    n_elapsed   = '0;
                    n_gate_open = 1'b0;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (i_word.metal_present) begin
                    n_mode    = MODE_WARN;
                    n_elapsed = '0;
                    n_buzzer  = 1'b1;
                end
                // a person wins over metal; buzzer stays latched
                if (i_word.light_level <= i_cfg.enter_threshold) begin
                    n_mode      = MODE_SETTLE;
                    n_count     = r_count + 16'd1;
                    n_counted   = 1'b1;
                    n_elapsed   = '0;
                    n_gate_open = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        unique case (n_mode)
            MODE_WARN:   mode_code = CODE_WARN;
            MODE_SETTLE: mode_code = CODE_SETTLE;
            MODE_LEAVE:  mode_code = CODE_LEAVE;
            MODE_HOLD:   mode_code = CODE_HOLD;
            default:     mode_code = CODE_IDLE;
        endcase
    end

    assign o_result.mode_code    = mode_code;
    assign o_result.gate_angle   = n_gate_open ? i_cfg.open_angle : i_cfg.closed_angle;
    assign o_result.buzzer_on    = n_buzzer;
    assign o_result.person_count = n_count;
    assign o_result.counted_now  = n_counted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_elapsed   <= '0;
            r_count     <= '0;
            r_buzzer    <= 1'b0;
            r_gate_open <= 1'b0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_count     <= n_count;
            r_buzzer    <= n_buzzer;
            r_gate_open <= n_gate_open;
        end
    end

    a_count_enters_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_counted) |=> (r_mode == MODE_SETTLE) &&
                                  (r_count == $past(r_count) + 16'd1))
        else $error("count step did not land in settle with count + 1");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_count) && $stable(r_elapsed))
        else $error("state moved without an accepted word");

    a_gate_tracks_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate_open == ((r_mode == MODE_SETTLE) || (r_mode == MODE_LEAVE) ||
                        (r_mode == MODE_HOLD)))
        else $error("gate latch disagrees with mode");

endmodule

/* hw/rtl/egc_obuf.sv */
// ============================================================================
// egc_obuf - two-entry output buffer
// Output register plus skid register, so the upstream stall is a register
// and a new word is taken while a result waits downstream.
// ============================================================================
module egc_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  egc_pkg::t_out_word i_word,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output egc_pkg::t_out_word o_out_word
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    egc_pkg::t_out_word r_out_word, n_out_word;
    egc_pkg::t_out_word r_skid_word, n_skid_word;
    logic               take;

    assign take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_word   = r_out_word;
        n_skid_word  = r_skid_word;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_word   = r_skid_word;
                n_skid_valid = i_push;
                n_skid_word  = i_word;
            end else begin
                n_out_valid = i_push;
                n_out_word  = i_word;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid_word  = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while output is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled without a stalled output");

    a_skid_drain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> r_out_valid && (r_out_word == $past(r_skid_word)))
        else $error("skid word not moved to output in order");

endmodule

/* hw/rtl/entry_gate_counter_fsm_top.sv */
// ============================================================================
// entry_gate_counter_fsm_top - entry gate person counter
// Per-tick gate state machine with warning buzzer, configuration registers
// and a buffered result channel.
// ============================================================================
// Each input word is one tick. A new word is accepted every cycle while
// o_in_stall is low; its result goes to the output register, or to the skid
// register while a result waits. A two-entry output buffer decouples the
// sides, so o_in_stall rises only after two results are waiting downstream.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// and should change only while no words are in flight.
module entry_gate_counter_fsm_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  egc_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output egc_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [egc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [egc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    egc_pkg::t_cfg      r_cfg;
    egc_pkg::t_out_word result;
    logic               full;
    logic               step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_threshold <= egc_pkg::RST_ENTER_THRESHOLD;
            r_cfg.leave_threshold <= egc_pkg::RST_LEAVE_THRESHOLD;
            r_cfg.settle_ticks    <= egc_pkg::RST_SETTLE_TICKS;
            r_cfg.hold_ticks      <= egc_pkg::RST_HOLD_TICKS;
            r_cfg.warn_ticks      <= egc_pkg::RST_WARN_TICKS;
            r_cfg.open_angle      <= egc_pkg::RST_OPEN_ANGLE;
            r_cfg.closed_angle    <= egc_pkg::RST_CLOSED_ANGLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                egc_pkg::REG_ENTER_THRESHOLD: r_cfg.enter_threshold <= i_cfg_data[11:0];
                egc_pkg::REG_LEAVE_THRESHOLD: r_cfg.leave_threshold <= i_cfg_data[11:0];
                egc_pkg::REG_SETTLE_TICKS:    r_cfg.settle_ticks    <= i_cfg_data;
                egc_pkg::REG_HOLD_TICKS:      r_cfg.hold_ticks      <= i_cfg_data;
                egc_pkg::REG_WARN_TICKS:      r_cfg.warn_ticks      <= i_cfg_data;
                egc_pkg::REG_OPEN_ANGLE:      r_cfg.open_angle      <= i_cfg_data[7:0];
                egc_pkg::REG_CLOSED_ANGLE:    r_cfg.closed_angle    <= i_cfg_data[7:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    assign step       = i_in_valid && !full;
    assign o_in_stall = full;

    egc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (step),
        .i_word   (i_in_word),
        .o_result (result)
    );

    egc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step),
        .i_word      (result),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
